// ===== rtl/core/lat_pkg.sv =====
// ----------------------------------------------------------------------------
// lat_pkg
// shared types and constants of the toroidal life engine
// ----------------------------------------------------------------------------
package lat_pkg;

    // fixed field widths
    localparam int CELL_W      = 64;  // row port width
    localparam int ROWNUM_W    = 6;   // emitted row index width
    localparam int GRID_DIM_W  = 7;   // width and height register width
    localparam int GEN_W       = 16;  // generation count width
    localparam int CFG_DATA_W  = 16;  // config write data width
    localparam int CFG_ADDR_W  = 2;   // config register index width

    // config register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GENERATIONS = 2'd2;

    // config reset values
    localparam logic [GRID_DIM_W-1:0] DIM_RESET = 7'd64;
    localparam logic [GEN_W-1:0]      GEN_RESET = 16'd1;

    // smallest grid side in use
    localparam int MIN_DIM = 3;

    // life rule
    localparam int NBR_W       = 4;   // holds a count of eight neighbors
    localparam int BIRTH_COUNT = 3;
    localparam int KEEP_COUNT  = 2;

    // controller to datapath commands
    typedef struct packed {
        logic load_we;   // write one input row
        logic rd_en;     // read one row of the current grid
        logic rd_emit;   // read feeds the result port, not the rule logic
        logic rd_flag;   // emit: last row; compute: window complete after this read
        logic flip;      // next grid becomes the current grid
    } t_dp_cmd;

endpackage

// ===== rtl/core/lat_ctrl.sv =====
// ----------------------------------------------------------------------------
// lat_ctrl
// sequencer for loading, generation sweeps and row emission
// ----------------------------------------------------------------------------
module lat_ctrl import lat_pkg::*; #(
    parameter int MAX_HEIGHT = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]      i_eff_h,
    input  logic [GEN_W-1:0]                     i_gens,
    input  logic                                 i_pipe_busy,
    output logic                                 o_busy,
    output t_dp_cmd                              o_cmd,
    output logic [$clog2(MAX_HEIGHT)-1:0]        o_row,
    output logic [$clog2(MAX_HEIGHT)-1:0]        o_tag
);

    localparam int AW = $clog2(MAX_HEIGHT);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int KW = $clog2(MAX_HEIGHT + 2);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_GEN    = 3'd1;
    localparam logic [2:0] S_GWAIT  = 3'd2;
    localparam logic [2:0] S_EMIT   = 3'd3;
    localparam logic [2:0] S_EDRAIN = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [AW-1:0]    r_rows,  n_rows;
    logic [KW-1:0]    r_k,     n_k;
    logic [GEN_W-1:0] r_gen,   n_gen;

    logic [KW-1:0]    h_k;
    logic [HW-1:0]    rows_nx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rows  <= '0;
            r_k     <= '0;
            r_gen   <= '0;
        end else begin
            r_state <= n_state;
            r_rows  <= n_rows;
            r_k     <= n_k;
            r_gen   <= n_gen;
        end
    end

    always_comb begin
        n_state = r_state;
        n_rows  = r_rows;
        n_k     = r_k;
        n_gen   = r_gen;
        o_cmd   = '0;
        o_row   = r_rows;
        o_tag   = '0;
        h_k     = KW'(i_eff_h);
        rows_nx = HW'(r_rows) + HW'(1);
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load_we = 1'b1;
                    if (rows_nx >= i_eff_h) begin
                        n_rows = '0;
                        n_k    = '0;
                        if (i_gens == '0) begin
                            n_state = S_EMIT;
                        end else begin
                            n_gen   = i_gens;
                            n_state = S_GEN;
                        end
                    end else begin
                        n_rows = r_rows + AW'(1);
                    end
                end
            end
            S_GEN: begin
                // read order: last row, then rows 0 to h-1, then row 0 again
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_flag = (r_k >= KW'(2));
                o_tag         = AW'(r_k - KW'(2));
                if (r_k == '0) begin
                    o_row = AW'(i_eff_h - HW'(1));
                end else if (r_k == h_k + KW'(1)) begin
                    o_row = '0;
                end else begin
                    o_row = AW'(r_k - KW'(1));
                end
                if (r_k == h_k + KW'(1)) begin
                    n_k     = '0;
                    n_state = S_GWAIT;
                end else begin
                    n_k = r_k + KW'(1);
                end
            end
            S_GWAIT: begin
                if (!i_pipe_busy) begin
                    o_cmd.flip = 1'b1;
                    if (r_gen == GEN_W'(1)) begin
                        n_state = S_EMIT;
                    end else begin
                        n_gen   = r_gen - GEN_W'(1);
                        n_state = S_GEN;
                    end
                end
            end
            S_EMIT: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_emit = 1'b1;
                o_row         = AW'(r_k);
                o_tag         = AW'(r_k);
                o_cmd.rd_flag = (r_k + KW'(1) == h_k);
                if (r_k + KW'(1) == h_k) begin
                    n_k     = '0;
                    n_state = S_EDRAIN;
                end else begin
                    n_k = r_k + KW'(1);
                end
            end
            S_EDRAIN: begin
                if (!i_pipe_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

`ifndef SYNTHESIS
    a_read_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_en |-> (HW'(o_row) < i_eff_h))
        else $error("row read outside the grid in use");

    a_busy_from_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_busy) |-> $past(i_start))
        else $error("engine started without an accepted item");
`endif

endmodule

// ===== rtl/core/lat_dpath.sv =====
// ----------------------------------------------------------------------------
// lat_dpath
// grid memory with two banks, three-row window and row-parallel life rule
// ----------------------------------------------------------------------------
module lat_dpath import lat_pkg::*; #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  t_dp_cmd                           i_cmd,
    input  logic [$clog2(MAX_HEIGHT)-1:0]     i_row,
    input  logic [$clog2(MAX_HEIGHT)-1:0]     i_tag,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]    i_eff_w,
    input  logic [MAX_WIDTH-1:0]              i_row_cells,
    output logic                              o_pipe_busy,
    output logic                              o_strobe,
    output logic [CELL_W-1:0]                 o_result_row,
    output logic [ROWNUM_W-1:0]               o_row_number,
    output logic                              o_final_row
);

    localparam int AW    = $clog2(MAX_HEIGHT);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int LW    = $clog2(MAX_WIDTH);
    localparam int DEPTH = 2 ** (AW + 1);

    logic [MAX_WIDTH-1:0] mem [0:DEPTH-1];

    logic                 r_bank;
    logic                 r_rvalid;
    logic                 r_remit;
    logic                 r_rflag;
    logic [AW-1:0]        r_rtag;
    logic [MAX_WIDTH-1:0] r_rdata;
    logic [MAX_WIDTH-1:0] r_up, r_mid, r_dn;
    logic                 r_wvalid;
    logic [AW-1:0]        r_wy;
    logic                 r_strobe;
    logic [MAX_WIDTH-1:0] r_out_row;
    logic [AW-1:0]        r_out_num;
    logic                 r_out_final;

    logic [MAX_WIDTH-1:0] mask;
    logic [WW-1:0]        wm1;
    logic [LW-1:0]        top_lane;
    logic [MAX_WIDTH-1:0] up_l, up_r, mid_l, mid_r, dn_l, dn_r;
    logic [MAX_WIDTH-1:0] nxt_row;
    logic [NBR_W-1:0]     cnt [MAX_WIDTH];

    // neighbor at x-1 moved into lane x, lane 0 takes the top lane in use;
    // bits left above the width by a narrower width later also fold in
    function automatic logic [MAX_WIDTH-1:0] from_left(
        input logic [MAX_WIDTH-1:0] r,
        input logic [LW-1:0]        top
    );
        return (r << 1) | (r >> top);
    endfunction

    // neighbor at x+1 moved into lane x, the top lane in use takes lane 0
    function automatic logic [MAX_WIDTH-1:0] from_right(
        input logic [MAX_WIDTH-1:0] r,
        input logic [LW-1:0]        top
    );
        return (r >> 1) | (r << top);
    endfunction

    always_comb begin
        wm1      = i_eff_w - WW'(1);
        top_lane = wm1[LW-1:0];
        for (int x = 0; x < MAX_WIDTH; x++) begin
            mask[x] = (x < int'(i_eff_w));
        end
        up_l  = from_left(r_up, top_lane);
        up_r  = from_right(r_up, top_lane);
        mid_l = from_left(r_mid, top_lane);
        mid_r = from_right(r_mid, top_lane);
        dn_l  = from_left(r_dn, top_lane);
        dn_r  = from_right(r_dn, top_lane);
        for (int x = 0; x < MAX_WIDTH; x++) begin
            cnt[x] = NBR_W'(up_l[x]) + NBR_W'(r_up[x]) + NBR_W'(up_r[x])
                   + NBR_W'(mid_l[x]) + NBR_W'(mid_r[x])
                   + NBR_W'(dn_l[x]) + NBR_W'(r_dn[x]) + NBR_W'(dn_r[x]);
            nxt_row[x] = mask[x] & ((cnt[x] == NBR_W'(BIRTH_COUNT))
                       | ((cnt[x] == NBR_W'(KEEP_COUNT)) & r_mid[x]));
        end
    end

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we) begin
            mem[{r_bank, i_row}] <= i_row_cells & mask;
        end else if (r_wvalid) begin
            mem[{~r_bank, r_wy}] <= nxt_row;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= mem[{r_bank, i_row}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank   <= 1'b0;
            r_rvalid <= 1'b0;
            r_wvalid <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            if (i_cmd.flip) begin
                r_bank <= ~r_bank;
            end
            r_rvalid <= i_cmd.rd_en;
            r_wvalid <= r_rvalid & ~r_remit & r_rflag;
            r_strobe <= r_rvalid & r_remit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_remit <= i_cmd.rd_emit;
        r_rflag <= i_cmd.rd_flag;
        r_rtag  <= i_tag;
        if (r_rvalid && !r_remit) begin
            r_up  <= r_mid;
            r_mid <= r_dn;
            r_dn  <= r_rdata;
            r_wy  <= r_rtag;
        end
        if (r_rvalid && r_remit) begin
            r_out_row   <= r_rdata & mask;
            r_out_num   <= r_rtag;
            r_out_final <= r_rflag;
        end
    end

    assign o_pipe_busy  = r_rvalid | r_wvalid;
    assign o_strobe     = r_strobe;
    assign o_result_row = CELL_W'(r_out_row);
    assign o_row_number = ROWNUM_W'(r_out_num);
    assign o_final_row  = r_out_final;

`ifndef SYNTHESIS
    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.load_we && r_wvalid))
        else $error("load write and generation write in the same cycle");

    a_last_row_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_final_row) |=> !o_strobe)
        else $error("row emitted after the final row");
`endif

endmodule

// ===== rtl/core/life_automaton_torus.sv =====
// ----------------------------------------------------------------------------
// life_automaton_torus
// toroidal game of life: row load, generation sweeps, row-by-row emission
// ----------------------------------------------------------------------------
// load: input rows are taken one per cycle while busy is low; after the
//   last row, each generation runs one sweep (one memory read per row plus
//   window fill and write drain), then the result rows follow, one per cycle
// one grid at a time: busy stays high until the last result row is out;
//   sweep speed is set by the single read port of the grid memory, one row
//   per cycle in every sweep
// reset: synchronous active-low i_rst_n returns to load at row 0 with
//   width 64, height 64, one generation; grid memory is not cleared
// results cannot be stalled: each row shows for one cycle with o_strobe
// ----------------------------------------------------------------------------
module life_automaton_torus import lat_pkg::*; #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // item port
    input  logic                    start,
    output logic                    busy,
    input  logic [CELL_W-1:0]       i_row_cells,
    // config port
    input  logic                    i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]   i_cfg_wdata,
    // result port
    output logic                    o_strobe,
    output logic [CELL_W-1:0]       o_result_row,
    output logic [ROWNUM_W-1:0]     o_row_number,
    output logic                    o_final_row
);

    localparam int AW = $clog2(MAX_HEIGHT);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    // config registers
    logic [GRID_DIM_W-1:0] r_cfg_w;
    logic [GRID_DIM_W-1:0] r_cfg_h;
    logic [GEN_W-1:0]      r_cfg_gens;

    // grid size in force, saturated into the supported range
    logic [WW-1:0]         eff_w;
    logic [HW-1:0]         eff_h;

    // controller to datapath
    t_dp_cmd               cmd;
    logic [AW-1:0]         row_addr;
    logic [AW-1:0]         row_tag;
    logic                  pipe_busy;

    // writes to unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w    <= DIM_RESET;
            r_cfg_h    <= DIM_RESET;
            r_cfg_gens <= GEN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_GRID_WIDTH:  r_cfg_w    <= i_cfg_wdata[GRID_DIM_W-1:0];
                REG_GRID_HEIGHT: r_cfg_h    <= i_cfg_wdata[GRID_DIM_W-1:0];
                REG_GENERATIONS: r_cfg_gens <= i_cfg_wdata[GEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // clamp width and height to MIN_DIM .. max
    always_comb begin
        if (r_cfg_w < GRID_DIM_W'(MIN_DIM)) begin
            eff_w = WW'(MIN_DIM);
        end else if (int'(r_cfg_w) > MAX_WIDTH) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(r_cfg_w);
        end
        if (r_cfg_h < GRID_DIM_W'(MIN_DIM)) begin
            eff_h = HW'(MIN_DIM);
        end else if (int'(r_cfg_h) > MAX_HEIGHT) begin
            eff_h = HW'(MAX_HEIGHT);
        end else begin
            eff_h = HW'(r_cfg_h);
        end
    end

    // sequencer: load count, sweep index, generations left
    lat_ctrl #(
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_eff_h     (eff_h),
        .i_gens      (r_cfg_gens),
        .i_pipe_busy (pipe_busy),
        .o_busy      (busy),
        .o_cmd       (cmd),
        .o_row       (row_addr),
        .o_tag       (row_tag)
    );

    // grid banks, row window, rule logic and result registers
    lat_dpath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_row        (row_addr),
        .i_tag        (row_tag),
        .i_eff_w      (eff_w),
        .i_row_cells  (i_row_cells[MAX_WIDTH-1:0]),
        .o_pipe_busy  (pipe_busy),
        .o_strobe     (o_strobe),
        .o_result_row (o_result_row),
        .o_row_number (o_row_number),
        .o_final_row  (o_final_row)
    );

`ifndef SYNTHESIS
    a_emit_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result row emitted while the engine is idle");
`endif

endmodule

// ===== test/life_grid_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// life_grid_checker
// tracks config writes and loaded rows, evolves its own copy of the torus and
// compares every emitted row against the predicted final grid
// ----------------------------------------------------------------------------
module life_grid_checker import lat_pkg::*; #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  logic [CELL_W-1:0]     i_row_cells,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_strobe,
    input  logic [CELL_W-1:0]     i_result_row,
    input  logic [ROWNUM_W-1:0]   i_row_number,
    input  logic                  i_final_row,
    output int                    o_fail_count,
    output int                    o_rows_pending
);

    typedef struct {
        logic [CELL_W-1:0]   cells;
        logic [ROWNUM_W-1:0] index;
        logic                last;
    } t_grid_row;

    t_grid_row             rows_due[$];
    logic [CELL_W-1:0]     board      [MAX_HEIGHT];
    logic [CELL_W-1:0]     board_next [MAX_HEIGHT];
    logic [GRID_DIM_W-1:0] width_reg;
    logic [GRID_DIM_W-1:0] height_reg;
    logic [GRID_DIM_W-1:0] rows_in;
    logic [GEN_W-1:0]      gen_reg;
    int                    mismatches = 0;

    function automatic logic [CELL_W-1:0] lane_mask(int w);
        return (w >= CELL_W) ? '1 : ((CELL_W'(1) << w) - CELL_W'(1));
    endfunction

    function automatic int clamp_dim(logic [GRID_DIM_W-1:0] v, int hi);
        if (v < MIN_DIM) return MIN_DIM;
        if (v > hi) return hi;
        return int'(v);
    endfunction

    // cell x-1 moved into lane x, wrapping inside w lanes
    function automatic logic [CELL_W-1:0] pull_left(logic [CELL_W-1:0] r, int w);
        return ((r << 1) | (r >> (w - 1))) & lane_mask(w);
    endfunction

    // cell x+1 moved into lane x
    function automatic logic [CELL_W-1:0] pull_right(logic [CELL_W-1:0] r, int w);
        return ((r >> 1) | (r << (w - 1))) & lane_mask(w);
    endfunction

    function automatic logic [CELL_W-1:0] rule_row(logic [CELL_W-1:0] above,
                                                   logic [CELL_W-1:0] here,
                                                   logic [CELL_W-1:0] below,
                                                   int w);
        logic [CELL_W-1:0] nbr [8];
        logic [CELL_W-1:0] ones, twos, fours, carry_a, carry_b;
        int k;
        nbr[0] = pull_left(above, w);
        nbr[1] = above;
        nbr[2] = pull_right(above, w);
        nbr[3] = pull_left(here, w);
        nbr[4] = pull_right(here, w);
        nbr[5] = pull_left(below, w);
        nbr[6] = below;
        nbr[7] = pull_right(below, w);
        ones  = '0;
        twos  = '0;
        fours = '0;
        // bit-sliced neighbor count, one counter per lane
        for (k = 0; k < 8; k++) begin
            carry_a = ones & nbr[k];
            ones    = ones ^ nbr[k];
            carry_b = twos & carry_a;
            twos    = twos ^ carry_a;
            fours   = fours ^ carry_b;
        end
        // three neighbors, or two around a live cell
        return twos & ~fours & (ones | here) & lane_mask(w);
    endfunction

    function automatic void step_board(int w, int h);
        int y;
        for (y = 0; y < h; y++)
            board_next[y] = rule_row(board[(y + h - 1) % h], board[y], board[(y + 1) % h], w);
        for (y = 0; y < h; y++)
            board[y] = board_next[y];
    endfunction

    function automatic void take_row(logic [CELL_W-1:0] cells);
        t_grid_row row_item;
        int w, h, g, y;
        w = clamp_dim(width_reg, (MAX_WIDTH < CELL_W) ? MAX_WIDTH : CELL_W);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        if (rows_in < MAX_HEIGHT)
            board[rows_in] = cells & lane_mask(w);
        rows_in = rows_in + 1'b1;
        if (rows_in >= h) begin
            rows_in = '0;
            for (g = 0; g < int'(gen_reg); g++)
                step_board(w, h);
            for (y = 0; y < h; y++) begin
                row_item.cells = board[y] & lane_mask(w);
                row_item.index = ROWNUM_W'(y);
                row_item.last  = (y == h - 1);
                rows_due.push_back(row_item);
            end
        end
    endfunction

    function automatic void check_row();
        t_grid_row want;
        if (rows_due.size() == 0) begin
            $error("row_number: no row expected, got %0d", i_row_number);
            mismatches++;
        end else begin
            want = rows_due.pop_front();
            if (i_result_row !== want.cells) begin
                $error("result_row: expected %h, got %h", want.cells, i_result_row);
                mismatches++;
            end
            if (i_row_number !== want.index) begin
                $error("row_number: expected %0d, got %0d", want.index, i_row_number);
                mismatches++;
            end
            if (i_final_row !== want.last) begin
                $error("final_row: expected %b, got %b", want.last, i_final_row);
                mismatches++;
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg  = DIM_RESET;
            height_reg = DIM_RESET;
            gen_reg    = GEN_RESET;
            rows_in    = '0;
            rows_due.delete();
        end else begin
            if (i_strobe)
                check_row();
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_GRID_WIDTH:  width_reg  = i_cfg_wdata[GRID_DIM_W-1:0];
                    REG_GRID_HEIGHT: height_reg = i_cfg_wdata[GRID_DIM_W-1:0];
                    REG_GENERATIONS: gen_reg    = i_cfg_wdata[GEN_W-1:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy)
                take_row(i_row_cells);
        end
        o_rows_pending <= rows_due.size();
        o_fail_count   <= mismatches;
    end

endmodule

// ===== test/life_automaton_torus_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// life_automaton_torus_tb
// drives grids into the toroidal life engine: a directed pass over the size
// extremes, saturation, zero and very long generation counts and mid-load
// size changes, then random grids of random size with random sender gaps;
// the checker predicts every emitted row and counts mismatches
// ----------------------------------------------------------------------------
module life_automaton_torus_tb;
    import lat_pkg::*;

    localparam int CYCLE_LIMIT  = 3_000_000;  // hang guard, above the slowest run
    localparam int DRAIN_CYCLES = 200;        // quiet time after the last row
    localparam int QUIET_CYCLES = 8;          // pause before a config write
    localparam int RANDOM_ROWS  = 200;        // items in the random part
    localparam int CALM_AFTER   = 160;        // no sender gaps beyond this
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 2'd3;  // unmapped index

    // row textures for random items
    typedef enum int {TEX_SPARSE, TEX_DENSE, TEX_FLAT, TEX_EVEN} t_texture;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  start       = 1'b0;
    logic                  busy;
    logic [CELL_W-1:0]     i_row_cells = '0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  o_strobe;
    logic [CELL_W-1:0]     o_result_row;
    logic [ROWNUM_W-1:0]   o_row_number;
    logic                  o_final_row;

    int fail_count;
    int rows_pending;
    int cycle_count = 0;
    int rows_sent   = 0;
    bit idle_on     = 1'b0;

    // 2 ns clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    life_automaton_torus DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_row_cells  (i_row_cells),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_strobe     (o_strobe),
        .o_result_row (o_result_row),
        .o_row_number (o_row_number),
        .o_final_row  (o_final_row)
    );

    // watches both channels and predicts every final grid
    life_grid_checker grid_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_row_cells    (i_row_cells),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_strobe       (o_strobe),
        .i_result_row   (o_result_row),
        .i_row_number   (o_row_number),
        .i_final_row    (o_final_row),
        .o_fail_count   (fail_count),
        .o_rows_pending (rows_pending)
    );

    // hang guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [CELL_W-1:0] random_row(t_texture texture);
        logic [CELL_W-1:0] a, b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case (texture)
            TEX_SPARSE: return a & b;
            TEX_DENSE:  return a | b;
            TEX_FLAT:   return ($urandom_range(0, 1) != 0) ? '1 : '0;
            default:    return a;
        endcase
    endfunction

    // register word for a grid side, with junk in the unused high bits and
    // sometimes an out-of-range value that saturates to the same side
    function automatic logic [CFG_DATA_W-1:0] dim_code(int dim);
        logic [CFG_DATA_W-1:0] code;
        code = CFG_DATA_W'($urandom);
        if (dim == MIN_DIM && $urandom_range(0, 1) != 0)
            code[GRID_DIM_W-1:0] = GRID_DIM_W'($urandom_range(0, MIN_DIM));
        else if (dim == CELL_W && $urandom_range(0, 1) != 0)
            code[GRID_DIM_W-1:0] = GRID_DIM_W'($urandom_range(CELL_W, 127));
        else
            code[GRID_DIM_W-1:0] = GRID_DIM_W'(dim);
        return code;
    endfunction

    // one register write; the trailing cycle keeps back-to-back writes clean
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_grid(input logic [CFG_DATA_W-1:0] w,
                            input logic [CFG_DATA_W-1:0] h,
                            input logic [CFG_DATA_W-1:0] gens);
        write_reg(REG_GRID_WIDTH, w);
        write_reg(REG_GRID_HEIGHT, h);
        write_reg(REG_GENERATIONS, gens);
    endtask

    // offer one item until taken, then maybe go quiet for a burst
    task automatic send_row(input logic [CELL_W-1:0] cells);
        start       <= 1'b1;
        i_row_cells <= cells;
        do @(posedge i_clk); while (busy !== 1'b0);
        rows_sent++;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    task automatic load_rows(input int n, input t_texture texture);
        repeat (n) send_row(random_row(texture));
    endtask

    // hold off until every predicted row is out and the block takes items
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (rows_pending != 0 || busy !== 1'b0) @(posedge i_clk);
    endtask

    task automatic settle();
        wait_drained();
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int       w_eff;
        int       h_eff;
        bit       first_big;
        t_texture texture;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        settle();

        // zero generations on the smallest torus, bits past the width dropped
        set_grid(16'd3, 16'd3, 16'd0);
        send_row('1);
        send_row('0);
        send_row(64'h8000_0000_0000_0005);
        settle();

        // full width: wrap across the side edges and the top/bottom seam
        set_grid(16'd64, 16'd3, 16'd1);
        repeat (3) send_row(64'h8000_0000_0000_0001);
        settle();

        // under-range sizes saturate up to three, even generation count
        set_grid(16'hFF80, 16'h0001, 16'd2);
        send_row(64'h7);
        send_row(64'h2);
        send_row(64'hFFFF_FFFF_FFFF_FFF8);
        settle();

        // over-range width saturates to 64, glider crossing the seam, with gaps
        idle_on = 1'b1;
        set_grid(16'h007F, 16'd5, 16'd3);
        send_row(64'h2);
        send_row(64'h4);
        send_row(64'h7);
        send_row(64'h0);
        send_row(64'h8000_0000_0000_0001);
        settle();

        // height lowered below the rows already taken: next row closes the grid
        set_grid(16'd10, 16'd6, 16'd1);
        load_rows(4, TEX_EVEN);
        settle();
        write_reg(REG_GRID_HEIGHT, 16'd3);
        load_rows(1, TEX_EVEN);
        settle();

        // width widened halfway through a load, unmapped index ignored
        set_grid(16'd8, 16'd4, 16'd2);
        send_row('1);
        send_row('1);
        settle();
        write_reg(REG_GRID_WIDTH, 16'd20);
        write_reg(REG_SPARE, 16'hFFFF);
        send_row('1);
        send_row(random_row(TEX_EVEN));
        settle();

        // longest generation count, on the shortest grid
        idle_on = 1'b0;
        set_grid(16'd64, 16'd3, 16'hFFFF);
        load_rows(3, TEX_EVEN);
        settle();

        // random grids: mostly small, one full-height grid first
        rows_sent = 0;
        first_big = 1'b1;
        h_eff     = MIN_DIM;
        while (rows_sent < RANDOM_ROWS) begin
            idle_on = (rows_sent < CALM_AFTER) && ($urandom_range(0, 2) != 0);
            // new geometry needs an idle block; otherwise grids follow back to back
            if (first_big || $urandom_range(0, 2) != 0) begin
                settle();
                case ($urandom_range(0, 5))
                    0:       w_eff = MIN_DIM;
                    1:       w_eff = CELL_W;
                    default: w_eff = $urandom_range(MIN_DIM, CELL_W);
                endcase
                if (first_big) begin
                    h_eff = CELL_W;
                end else begin
                    case ($urandom_range(0, 7))
                        0:       h_eff = MIN_DIM;
                        1:       h_eff = $urandom_range(9, 16);
                        default: h_eff = $urandom_range(MIN_DIM, 8);
                    endcase
                end
                // height 100 saturates to a full 64-row grid
                set_grid(dim_code(w_eff), first_big ? 16'd100 : dim_code(h_eff),
                         ($urandom_range(0, 5) == 0) ? CFG_DATA_W'($urandom_range(20, 40))
                                                     : CFG_DATA_W'($urandom_range(0, 5)));
                first_big = 1'b0;
            end
            texture = t_texture'($urandom_range(0, 3));
            load_rows(h_eff, texture);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && rows_pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
